[rtl/c5sp_pkg.sv]
// c5sp_pkg: widths, limits and the character-to-code table of the
// 5-bit string packer. No dependencies; used by the interfaces and the core.
package c5sp_pkg;

   localparam int CP_W     = 21;  // code point width
   localparam int CODE_W   = 5;   // width of one packed code
   localparam int SLOTS    = 12;  // codes that fit in the wide word
   localparam int ACC_W    = CODE_W * SLOTS;
   localparam int CNT_W    = 4;

   localparam logic [CNT_W-1:0] LIMIT_NARROW = CNT_W'(6);
   localparam logic [CNT_W-1:0] LIMIT_WIDE   = CNT_W'(12);
   localparam logic [CNT_W-1:0] ITEM_SAT     = CNT_W'(13);

   // code returned for a character outside the alphabet
   localparam logic [CODE_W-1:0] CODE_NONE = '0;

   // ASCII code point to alphabet code 1..31, CODE_NONE if not a member
   function automatic logic [CODE_W-1:0] char5_code(input logic [6:0] ch);
      logic [CODE_W-1:0] code;
      begin
         case (ch)
            7'h2E: code = 5'd1;   // '.'
            7'h41: code = 5'd2;   // 'A'
            7'h43: code = 5'd3;   // 'C'
            7'h44: code = 5'd4;   // 'D'
            7'h45: code = 5'd5;   // 'E'
            7'h49: code = 5'd6;   // 'I'
            7'h4E: code = 5'd7;   // 'N'
            7'h4F: code = 5'd8;   // 'O'
            7'h50: code = 5'd9;   // 'P'
            7'h53: code = 5'd10;  // 'S'
            7'h54: code = 5'd11;  // 'T'
            7'h5F: code = 5'd12;  // '_'
            7'h61: code = 5'd13;  // 'a'
            7'h62: code = 5'd14;  // 'b'
            7'h63: code = 5'd15;  // 'c'
            7'h64: code = 5'd16;  // 'd'
            7'h65: code = 5'd17;  // 'e'
            7'h66: code = 5'd18;  // 'f'
            7'h67: code = 5'd19;  // 'g'
            7'h68: code = 5'd20;  // 'h'
            7'h69: code = 5'd21;  // 'i'
            7'h6C: code = 5'd22;  // 'l'
            7'h6D: code = 5'd23;  // 'm'
            7'h6E: code = 5'd24;  // 'n'
            7'h6F: code = 5'd25;  // 'o'
            7'h70: code = 5'd26;  // 'p'
            7'h72: code = 5'd27;  // 'r'
            7'h73: code = 5'd28;  // 's'
            7'h74: code = 5'd29;  // 't'
            7'h75: code = 5'd30;  // 'u'
            7'h79: code = 5'd31;  // 'y'
            default: code = CODE_NONE;
         endcase
         return code;
      end
   endfunction

endpackage

[rtl/c5sp_req_if.sv]
// c5sp_req_if: input channel of the string packer, one character a word.
// Depends on c5sp_pkg for the code point width.
interface c5sp_req_if import c5sp_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            last;

   modport source (output valid, output code_point, output last, input ready);
   modport sink   (input valid, input code_point, input last, output ready);
endinterface

[rtl/c5sp_rsp_if.sv]
// c5sp_rsp_if: result channel of the string packer, one packed string a word.
// Depends on c5sp_pkg for the packed word and count widths.
interface c5sp_rsp_if import c5sp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ACC_W-1:0] packed_res;
   logic [CNT_W-1:0] char_count;
   logic             valid_res;

   modport source (output valid, output packed_res, output char_count,
                   output valid_res, input ready);
   modport sink   (input valid, input packed_res, input char_count,
                   input valid_res, output ready);
endinterface

[rtl/char5_string_packer_core.sv]
// char5_string_packer_core: packs a character string into 5-bit codes.
// Depends on c5sp_pkg, c5sp_req_if and c5sp_rsp_if.
//
// Usage:
//   req_chan carries one character per word (code_point, last). Characters
//   are mapped to 5-bit codes and packed first character lowest. A zero
//   character ends the string; later characters are counted only.
//   On the word with last set, one word leaves on rsp_chan: packed_res,
//   char_count and valid_res (clear if a character was outside the alphabet
//   or the string had more words than the mode allows).
//   csr_wr_en/csr_wr_data write wide_mode (0: 6 chars, 1: 12 chars); write
//   it only while no string is in flight.
// Timing:
//   One character per cycle sustained, unless a last word waits on a
//   stalled rsp_chan. A character is held in the input register, then
//   updates the packing state; the result of a last word goes into the
//   result register as it leaves the input register, and rsp_chan shows it.
//   The combinational table lookup and slot insert set this rate.
// Reset and stall:
//   reset clears the string state and both registers and sets wide_mode.
//   If rsp_chan stalls with a result pending, the input register still
//   takes one more word; non-last words keep flowing, a last word waits.
module char5_string_packer_core
   import c5sp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   c5sp_req_if.sink   req_chan,
   c5sp_rsp_if.source rsp_chan,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);

   // configuration
   logic wide_mode_ff;

   // input register
   logic            s1_valid_ff, s1_valid_in;
   logic [CP_W-1:0] s1_cp_ff;
   logic            s1_last_ff;

   // packing state
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] packed_count_ff, packed_count_in;
   logic [CNT_W-1:0] item_count_ff, item_count_in;
   logic             string_ended_ff, string_ended_in;
   logic             bad_char_ff, bad_char_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0] rsp_packed_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_ok_ff;

   logic             advance;
   logic             emit;
   logic [CNT_W-1:0] limit;
   logic [CODE_W-1:0] code;
   logic             res_ok;

   // stage 1 moves on unless it holds a last word and the result is blocked
   assign advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign emit    = advance && s1_last_ff;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign s1_valid_in    = (req_chan.valid && req_chan.ready) || (s1_valid_ff && !advance);

   assign limit = wide_mode_ff ? LIMIT_WIDE : LIMIT_NARROW;
   assign code  = (s1_cp_ff[CP_W-1:7] == '0) ? char5_code(s1_cp_ff[6:0]) : CODE_NONE;

   // next packing state for the word in stage 1
   always_comb begin
      acc_in          = acc_ff;
      packed_count_in = packed_count_ff;
      string_ended_in = string_ended_ff;
      bad_char_in     = bad_char_ff;
      item_count_in   = (item_count_ff < ITEM_SAT) ? item_count_ff + CNT_W'(1)
                                                    : item_count_ff;
      if (!string_ended_ff) begin
         if (s1_cp_ff == '0) begin
            string_ended_in = 1'b1;
         end else if (code == CODE_NONE) begin
            bad_char_in = 1'b1;
         end else if (packed_count_ff < limit) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (packed_count_ff == CNT_W'(i)) begin
                  acc_in[i*CODE_W +: CODE_W] = code;
               end
            end
            packed_count_in = packed_count_ff + CNT_W'(1);
         end
      end
   end

   assign res_ok = !bad_char_in && (item_count_in <= limit);

   // result valid: set on a last word, cleared once taken
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wide_mode_ff    <= 1'b1;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         acc_ff          <= '0;
         packed_count_ff <= '0;
         item_count_ff   <= '0;
         string_ended_ff <= 1'b0;
         bad_char_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            wide_mode_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            if (s1_last_ff) begin
               acc_ff          <= '0;
               packed_count_ff <= '0;
               item_count_ff   <= '0;
               string_ended_ff <= 1'b0;
               bad_char_ff     <= 1'b0;
            end else begin
               acc_ff          <= acc_in;
               packed_count_ff <= packed_count_in;
               item_count_ff   <= item_count_in;
               string_ended_ff <= string_ended_in;
               bad_char_ff     <= bad_char_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_cp_ff   <= req_chan.code_point;
         s1_last_ff <= req_chan.last;
      end
      if (emit) begin
         rsp_packed_ff <= acc_in;
         rsp_count_ff  <= packed_count_in;
         rsp_ok_ff     <= res_ok;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.packed_res = rsp_packed_ff;
   assign rsp_chan.char_count = rsp_count_ff;
   assign rsp_chan.valid_res  = rsp_ok_ff;

   // checks
   a_packed_le_items: assert property (@(posedge clock) disable iff (reset)
      packed_count_ff <= item_count_ff)
      else $error("packed count ran ahead of item count");

   a_packed_in_range: assert property (@(posedge clock) disable iff (reset)
      packed_count_ff <= LIMIT_WIDE)
      else $error("packed count beyond twelve");

   a_ok_within_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ok_ff) |-> (rsp_count_ff <= limit))
      else $error("string flagged good with too many characters");

   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff && !advance) |=> (s1_valid_ff && s1_last_ff))
      else $error("blocked last word lost from input register");

endmodule

[sim/c5sp_pack_checker.sv]
// c5sp_pack_checker: watches the character and result channels of the
// 5-bit string packer, predicts each packed word and compares it.
// Depends on c5sp_pkg, c5sp_req_if and c5sp_rsp_if.
`timescale 1ns / 1ps

module c5sp_pack_checker
   import c5sp_pkg::*;
#(
   parameter logic [8*31-1:0] CHARSET = '0  // alphabet, first char in top byte
)(
   input  logic clock,
   input  logic reset,
   c5sp_req_if  req_mon,
   c5sp_rsp_if  rsp_mon,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   output int   mismatches,
   output int   outstanding
);

   typedef struct packed {
      logic [ACC_W-1:0] word;
      logic [CNT_W-1:0] count;
      logic             ok;
   } packed_str_type;

   // shadow of the block's string state and mode
   logic             wide;
   logic [ACC_W-1:0] acc;
   logic [CNT_W-1:0] n_packed;
   logic [CNT_W-1:0] n_items;
   logic             ended;
   logic             bad;
   packed_str_type   packed_q[$];
   int               nerr = 0;

   // alphabet position + 1, or CODE_NONE for a non-member
   function automatic logic [CODE_W-1:0] char_code(input logic [CP_W-1:0] cp);
      for (int i = 0; i < 31; i++)
         if (cp == {{(CP_W-8){1'b0}}, CHARSET[8*(30-i) +: 8]})
            return CODE_W'(i + 1);
      return CODE_NONE;
   endfunction

   task automatic clear_string();
      acc      = '0;
      n_packed = '0;
      n_items  = '0;
      ended    = 1'b0;
      bad      = 1'b0;
   endtask

   // fold one accepted character into the shadow state
   task automatic absorb_char(input logic [CP_W-1:0] cp, input logic lst);
      logic [CNT_W-1:0]  cap;
      logic [CODE_W-1:0] code;
      packed_str_type    res;
      cap = wide ? LIMIT_WIDE : LIMIT_NARROW;
      if (n_items < ITEM_SAT) n_items++;
      if (!ended) begin
         if (cp == '0) begin
            ended = 1'b1;
         end else begin
            code = char_code(cp);
            if (code == CODE_NONE) begin
               bad = 1'b1;
            end else if (n_packed < cap) begin
               acc = acc | (ACC_W'(code) << (CODE_W * n_packed));
               n_packed++;
            end
         end
      end
      if (lst) begin
         res.word  = acc;
         res.count = n_packed;
         res.ok    = !bad && (n_items <= cap);
         packed_q.push_back(res);
         clear_string();
      end
   endtask

   // compare one result word with the oldest prediction
   task automatic check_result();
      packed_str_type want;
      if (packed_q.size() == 0) begin
         nerr++;
         if (nerr <= 10)
            $display("unexpected result word: packed %h count %0d valid %0d",
                     rsp_mon.packed_res, rsp_mon.char_count, rsp_mon.valid_res);
      end else begin
         want = packed_q.pop_front();
         if (rsp_mon.packed_res !== want.word || rsp_mon.char_count !== want.count ||
             rsp_mon.valid_res !== want.ok) begin
            nerr++;
            if (nerr <= 10)
               $display("mismatch: packed exp %h got %h, count exp %0d got %0d, ok exp %0d got %0d",
                        want.word, rsp_mon.packed_res, want.count, rsp_mon.char_count,
                        want.ok, rsp_mon.valid_res);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wide = 1'b1;
         clear_string();
         packed_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (req_mon.valid && req_mon.ready) absorb_char(req_mon.code_point, req_mon.last);
         if (csr_wr_en) wide = csr_wr_data;
      end
      mismatches  <= nerr;
      outstanding <= packed_q.size();
   end

endmodule

[sim/tb_char5_string_packer_core.sv]
// tb_char5_string_packer_core: drives strings into the 5-bit string packer
// in both modes with random idling and gives the verdict.
// Depends on c5sp_pkg, the channel interfaces, the core and c5sp_pack_checker.
`timescale 1ns / 1ps

module tb_char5_string_packer_core;
   import c5sp_pkg::*;

   localparam logic [8*31-1:0] CHARSET = ".ACDEINOPST_abcdefghilmnoprstuy";
   localparam logic MODE_NARROW = 1'b0;
   localparam logic MODE_WIDE   = 1'b1;
   localparam int   CYCLE_LIMIT = 200000;
   localparam int   RAND_CHARS  = 1400;
   localparam int   N_PHASES    = 6;

   typedef enum int {STR_CLEAN, STR_LONG, STR_NOISY, STR_CUT} str_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic csr_wr_data;
   int   mismatches;
   int   outstanding;
   int   cycles = 0;
   int   sent = 0;
   bit   steady = 1'b0;    // no idling on either side while set
   logic wide = MODE_WIDE;

   c5sp_req_if req_chan();
   c5sp_rsp_if rsp_chan();

   char5_string_packer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   c5sp_pack_checker #(.CHARSET(CHARSET)) pack_chk (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int idle_cycles();
      return steady ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic logic [CP_W-1:0] alpha_char(input int idx);
      return {{(CP_W-8){1'b0}}, CHARSET[8*(30-idx) +: 8]};
   endfunction

   // nonzero character that is mostly outside the alphabet
   function automatic logic [CP_W-1:0] noise_char();
      logic [CP_W-1:0] cp;
      case ($urandom_range(0, 3))
         0:       cp = CP_W'($urandom_range(1, 127));
         1:       cp = CP_W'($urandom_range(128, 1114111));
         2:       cp = CP_W'($urandom) | CP_W'(1);
         default: cp = ~CP_W'($urandom_range(0, 255));
      endcase
      return cp;
   endfunction

   // one character word, held until taken
   task automatic push_char(input logic [CP_W-1:0] cp, input logic lst);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.code_point <= cp;
      req_chan.last       <= lst;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      sent++;
   endtask

   // hold off until every packed word has come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      wide = m;
   endtask

   // one string of random shape for the current mode
   task automatic push_random_string();
      str_kind_type    kind;
      int              cap, len, cut, pick;
      bit              zero_end;
      logic [CP_W-1:0] cp;
      cap  = wide ? 12 : 6;
      pick = $urandom_range(0, 9);
      kind = pick < 6 ? STR_CLEAN : pick < 7 ? STR_LONG : pick < 9 ? STR_NOISY : STR_CUT;
      case (kind)
         STR_LONG: len = $urandom_range(cap + 1, 20);
         STR_CUT:  len = $urandom_range(2, cap + 2);
         default:  len = $urandom_range(1, cap);
      endcase
      cut      = $urandom_range(0, len - 1);
      zero_end = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < len; i++) begin
         if (kind == STR_CUT && i == cut)
            cp = '0;
         else if (kind == STR_CLEAN && zero_end && i == len - 1)
            cp = '0;
         else if ((kind == STR_NOISY || (kind == STR_CUT && i > cut)) &&
                  $urandom_range(0, 3) == 0)
            cp = noise_char();
         else
            cp = alpha_char($urandom_range(0, 30));
         push_char(cp, i == len - 1);
      end
   endtask

   // result side: random stalls per word
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin
      int target;
      req_chan.valid      = 1'b0;
      req_chan.code_point = '0;
      req_chan.last       = 1'b0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single char, empty string, wide overflow by one
      push_char(alpha_char(1), 1'b1);
      push_char('0, 1'b1);
      for (int i = 0; i < 13; i++)
         push_char(alpha_char(i == 1 ? 30 : i), i == 12);
      // char outside the alphabet, all code point bits set
      push_char({CP_W{1'b1}}, 1'b0);
      push_char(alpha_char(30), 1'b1);
      // characters after the terminator are only counted, not packed
      push_char(alpha_char(12), 1'b0);
      push_char('0, 1'b0);
      push_char(CP_W'(128), 1'b1);
      // narrow mode, one char past the limit
      write_mode(MODE_NARROW);
      for (int i = 0; i < 7; i++)
         push_char(alpha_char(30 - i), i == 6);

      // random phases, mode alternating
      for (int p = 0; p < N_PHASES; p++) begin
         write_mode((p % 2 == 0) ? MODE_WIDE : MODE_NARROW);
         steady = (p == 2);
         target = sent + RAND_CHARS / N_PHASES;
         while (sent < target) begin
            push_random_string();
            if ($urandom_range(0, 39) == 0) drain();
         end
      end
      steady = 1'b0;

      drain();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[char5_string_packer_core.f]
rtl/c5sp_pkg.sv
rtl/c5sp_req_if.sv
rtl/c5sp_rsp_if.sv
rtl/char5_string_packer_core.sv
sim/c5sp_pack_checker.sv
sim/tb_char5_string_packer_core.sv
